// ----- src/b2da_pkg.sv -----
package b2da_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int CHAR_W     = 6;
   localparam int CNT_W      = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [IDX_W-1:0]   TOP_IDX    = IDX_W'(NUM_DIGITS - 1);
   localparam logic [CNT_W-1:0]   LAST_SHIFT = CNT_W'(VALUE_W - 1);
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

   // controller -> datapath
   typedef struct packed {
      logic load;      // take a new value, clear the BCD digits
      logic shift;     // one add-3 and shift step
      logic idx_init;  // point at the most significant digit
      logic idx_dec;   // step to the next lower digit
      logic emit;      // load the output register from the current digit
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic digit_zero;  // current digit is zero
      logic idx_zero;    // current digit is the units digit
   } status_type;

endpackage

// ----- src/b2da_datapath.sv -----
module b2da_datapath
   import b2da_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [VALUE_W-1:0]  value,
   output status_type          status,
   output logic [CHAR_W-1:0]   ascii_char,
   output logic                last_char
);

   logic [VALUE_W-1:0] work_ff, work_in;
   logic [DIGIT_W-1:0] bcd_ff [NUM_DIGITS];
   logic [DIGIT_W-1:0] bcd_in [NUM_DIGITS];
   logic [DIGIT_W-1:0] adj    [NUM_DIGITS];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [DIGIT_W-1:0] cur_digit;

   assign cur_digit = bcd_ff[idx_ff];

   // double dabble step: add 3 to digits of 5 or more, then shift left by one
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= ADJ_LIMIT) ? bcd_ff[i] + ADJ_ADD : bcd_ff[i];
      end
      work_in = work_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_in[i] = bcd_ff[i];
      end
      if (cmd.load) begin
         work_in = value;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_in[i] = '0;
         end
      end else if (cmd.shift) begin
         work_in   = {work_ff[VALUE_W-2:0], 1'b0};
         bcd_in[0] = {adj[0][DIGIT_W-2:0], work_ff[VALUE_W-1]};
         for (int i = 1; i < NUM_DIGITS; i++) begin
            bcd_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         idx_in = TOP_IDX;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.emit) begin
         char_in = ASCII_ZERO + CHAR_W'(cur_digit);
         last_in = status.idx_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_ff[i] <= '0;
         end
         idx_ff  <= '0;
         char_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         work_ff <= work_in;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_ff[i] <= bcd_in[i];
         end
         idx_ff  <= idx_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign status.digit_zero = (cur_digit == '0);
   assign status.idx_zero   = (idx_ff == '0);
   assign ascii_char        = char_ff;
   assign last_char         = last_ff;

endmodule

// ----- src/b2da_ctrl.sv -----
module b2da_ctrl
   import b2da_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_SHIFT) begin
               cmd.idx_init = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // skip leading zeros, the units digit always prints
            if (status.digit_zero && !status.idx_zero) begin
               cmd.idx_dec = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               if (status.idx_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_dec = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- src/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter, 32-bit unsigned.
// Input stream (req_): one transfer carries one value in req_tdata.
// Output stream (rsp_): one transfer per decimal character, most significant
// digit first, leading zeros dropped (zero prints as a single '0');
// rsp_tlast marks the units digit of each value.
// Timing: after the input transfer the value goes through 32 add-3/shift
// steps of the BCD datapath, one per cycle, then leading zero digits are
// skipped at one per cycle (up to 9), a final scan step finds the first
// digit, then one character is loaded into the output register per cycle
// while the receiver keeps up. The controller returns to idle after the
// last character is loaded, and only one value is in work at a time.
// req_tready is high only while the controller is idle; the next value is
// accepted while the final character still waits in the output register.
// Receiver stall: the output register holds its character, the controller
// waits in its emit step, nothing is dropped.
// Reset (synchronous, active high) returns to idle with no output pending.
module binary_to_decimal_ascii
   import b2da_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] ascii_char, [7:6] zero
   output logic        rsp_tlast    // last_char
);

   cmd_type           cmd;
   status_type        status;
   logic [CHAR_W-1:0] ascii_char;
   logic              last_char;

   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value      (req_tdata),
      .status     (status),
      .ascii_char (ascii_char),
      .last_char  (last_char)
   );

   assign rsp_tdata = {2'b00, ascii_char};
   assign rsp_tlast = last_char;

`ifndef SYNTHESIS
   // one value at a time: an accepted transfer closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted during conversion");

   // a pending non-final character means the run is still being emitted
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("input open while a run is unfinished");

   // characters are decimal digits only
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'd48 && rsp_tdata <= 8'd57))
      else $error("output character not a decimal digit");

   // conversion takes 32 steps: no new character starts right after an accept
   a_conv_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !(rsp_tvalid && !$past(rsp_tvalid)))
      else $error("character emitted during conversion");
`endif

endmodule
